/* design/rvd_pkg.sv */
// Shared types and constants for the RMS vector distance block.
package rvd_pkg;

	localparam int unsigned MAX_LENGTH = 1024;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned SUM_W = 42;
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned SQ_W = 32;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned ROOT_W = SUM_W / 2;
	localparam int unsigned SREM_W = ROOT_W + 2;
	localparam int unsigned STEP_W = 6;
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned SQRT_STEPS = ROOT_W;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// One finished descriptor: its sum of squares and the length it used.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] len;
	} desc_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_DONE
	} back_state_t;

endpackage

/* design/rvd_front.sv */
// Front end: accepts element pairs, squares differences and accumulates a descriptor.
module rvd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rvd_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [rvd_pkg::ELEM_W-1:0] elem_a,
	input  logic signed [rvd_pkg::ELEM_W-1:0] elem_b,
	input  logic                       q_full,
	output logic                       push,
	output rvd_pkg::desc_t             push_data
);

	logic [rvd_pkg::LEN_W-1:0]  desc_length_q;
	logic [rvd_pkg::LEN_W-1:0]  eff_len;
	logic                       valid_s1;
	logic [rvd_pkg::SQ_W-1:0]   sq_s1;
	logic [rvd_pkg::SUM_W-1:0]  sum_q;
	logic [rvd_pkg::LEN_W-1:0]  count_q;
	logic signed [rvd_pkg::ELEM_W:0] diff;
	logic [rvd_pkg::ELEM_W:0]   mag_full;
	logic [rvd_pkg::ELEM_W-1:0] mag;
	logic [rvd_pkg::SUM_W:0]    sum_ext;
	logic [rvd_pkg::SUM_W-1:0]  sum_sat;
	logic [rvd_pkg::LEN_W:0]    count_next;
	logic                       advance;
	logic                       done;

	always_comb begin
		if (desc_length_q == '0) begin
			eff_len = rvd_pkg::LEN_W'(1);
		end else if (desc_length_q > rvd_pkg::LEN_W'(rvd_pkg::MAX_LENGTH)) begin
			eff_len = rvd_pkg::LEN_W'(rvd_pkg::MAX_LENGTH);
		end else begin
			eff_len = desc_length_q;
		end
	end

	// The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
	assign diff     = {elem_a[rvd_pkg::ELEM_W-1], elem_a} - {elem_b[rvd_pkg::ELEM_W-1], elem_b};
	assign mag_full = diff[rvd_pkg::ELEM_W] ? (~diff + 1'b1) : diff;
	assign mag      = mag_full[rvd_pkg::ELEM_W-1:0];

	assign advance  = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	assign sum_ext    = {1'b0, sum_q} + {{(rvd_pkg::SUM_W + 1 - rvd_pkg::SQ_W){1'b0}}, sq_s1};
	assign sum_sat    = sum_ext[rvd_pkg::SUM_W] ? '1 : sum_ext[rvd_pkg::SUM_W-1:0];
	assign count_next = {1'b0, count_q} + 1'b1;
	assign done       = count_next >= {1'b0, eff_len};

	assign push          = advance && done;
	assign push_data.sum = sum_sat;
	assign push_data.len = eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_length_q <= rvd_pkg::LEN_W'(128);
		end else if (cfg_we) begin
			desc_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sq_s1 <= mag * mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (advance) begin
			if (done) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_sat;
				count_q <= count_next[rvd_pkg::LEN_W-1:0];
			end
		end
	end

endmodule

/* design/rvd_queue.sv */
// Two-entry queue of finished descriptors between the front and back ends.
module rvd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvd_pkg::desc_t push_data,
	input  logic           pop,
	output rvd_pkg::desc_t pop_data,
	output logic           full,
	output logic           empty
);

	rvd_pkg::desc_t               entries [rvd_pkg::QDEPTH];
	logic [rvd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rvd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rvd_pkg::QCNT_W-1:0]   count_q;

	assign full     = count_q == rvd_pkg::QCNT_W'(rvd_pkg::QDEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rvd_pkg::QPTR_W'(rvd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == rvd_pkg::QPTR_W'(rvd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/rvd_back.sv */
// Back end: divides the sum by the length, takes the integer root and holds the result word.
module rvd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  rvd_pkg::desc_t              q_data,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rvd_pkg::DIST_W-1:0]  distance
);

	rvd_pkg::back_state_t         state_q;
	rvd_pkg::back_state_t         state_next;
	logic [rvd_pkg::LEN_W-1:0]    len_q;
	logic [rvd_pkg::LEN_W-1:0]    rem_q;
	logic [rvd_pkg::SUM_W-1:0]    quo_q;
	logic [rvd_pkg::STEP_W-1:0]   step_q;
	logic [rvd_pkg::SREM_W-1:0]   srem_q;
	logic [rvd_pkg::ROOT_W-1:0]   root_q;
	logic [rvd_pkg::DIST_W-1:0]   dist_q;
	logic                         out_valid_q;
	logic [rvd_pkg::LEN_W:0]      div_trial;
	logic                         div_ge;
	logic [rvd_pkg::LEN_W:0]      div_diff;
	logic [rvd_pkg::SREM_W+1:0]   sq_shift;
	logic [rvd_pkg::SREM_W+1:0]   sq_trial;
	logic                         sq_ge;
	logic [rvd_pkg::SREM_W+1:0]   sq_diff;
	logic                         load;
	logic                         last_step;

	assign div_trial = {rem_q, quo_q[rvd_pkg::SUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, len_q};
	assign div_diff  = div_trial - {1'b0, len_q};

	// Two bits of the quotient enter the root remainder each step.
	assign sq_shift = {srem_q, quo_q[rvd_pkg::SUM_W-1 -: 2]};
	assign sq_trial = {{(rvd_pkg::SREM_W - rvd_pkg::ROOT_W){1'b0}}, root_q, 2'b01};
	assign sq_ge    = sq_shift >= sq_trial;
	assign sq_diff  = sq_shift - sq_trial;

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		load       = 1'b0;
		last_step  = 1'b0;
		unique case (state_q)
			rvd_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop        = 1'b1;
					state_next = rvd_pkg::BK_DIV;
				end
			end
			rvd_pkg::BK_DIV: begin
				last_step = step_q == rvd_pkg::STEP_W'(rvd_pkg::DIV_STEPS - 1);
				if (last_step) begin
					state_next = rvd_pkg::BK_SQRT;
				end
			end
			rvd_pkg::BK_SQRT: begin
				last_step = step_q == rvd_pkg::STEP_W'(rvd_pkg::SQRT_STEPS - 1);
				if (last_step) begin
					state_next = rvd_pkg::BK_DONE;
				end
			end
			rvd_pkg::BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load       = 1'b1;
					state_next = rvd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_next = rvd_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvd_pkg::BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rvd_pkg::BK_IDLE: begin
				len_q  <= q_data.len;
				quo_q  <= q_data.sum;
				rem_q  <= '0;
				step_q <= '0;
			end
			rvd_pkg::BK_DIV: begin
				rem_q  <= div_ge ? div_diff[rvd_pkg::LEN_W-1:0] : div_trial[rvd_pkg::LEN_W-1:0];
				quo_q  <= {quo_q[rvd_pkg::SUM_W-2:0], div_ge};
				step_q <= last_step ? '0 : step_q + 1'b1;
				srem_q <= '0;
				root_q <= '0;
			end
			rvd_pkg::BK_SQRT: begin
				srem_q <= sq_ge ? sq_diff[rvd_pkg::SREM_W-1:0] : sq_shift[rvd_pkg::SREM_W-1:0];
				root_q <= {root_q[rvd_pkg::ROOT_W-2:0], sq_ge};
				quo_q  <= {quo_q[rvd_pkg::SUM_W-3:0], 2'b00};
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			dist_q <= (root_q[rvd_pkg::ROOT_W-1:rvd_pkg::DIST_W] != '0) ? '1
			          : root_q[rvd_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_div_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rvd_pkg::BK_DIV |-> rem_q < len_q)
		else $error("division remainder reached the divisor");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == rvd_pkg::BK_IDLE && !q_empty)
		else $error("queue popped outside idle or while empty");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid_q || out_ready)
		else $error("result word overwritten before it was taken");

	a_idle_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> state_q == rvd_pkg::BK_IDLE && out_valid_q)
		else $error("result load did not return the back end to idle");

endmodule

/* design/rms_vector_distance.sv */
// Top level of the RMS distance block: front end, descriptor queue and back end.
// One pair of signed Q4.12 elements is accepted per clock while the descriptor
// queue is not full. Each finished descriptor then occupies the back end for one
// queue pop, 42 restoring division steps, 21 two-bit square root steps and the
// load of the output register, after which the distance word is held in an output
// register until it is taken. The queue holds two finished descriptors; the input
// rate for short descriptors is limited by the shared divide and root unit, which
// takes a new descriptor only when it has loaded the result of the last. A pair's
// square is registered in the front pipeline before it reaches the accumulator.
module rms_vector_distance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rvd_pkg::LEN_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [rvd_pkg::ELEM_W-1:0] elem_a,
	input  logic signed [rvd_pkg::ELEM_W-1:0] elem_b,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rvd_pkg::DIST_W-1:0]        distance
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	rvd_pkg::desc_t push_data;
	rvd_pkg::desc_t pop_data;

	rvd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	rvd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	rvd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance)
	);

endmodule
